/* rtl/i2r_pkg.sv */
// Shared types, constants and the digit alphabet for the radix text unit.
package i2r_pkg;

    localparam int IN_W            = 64;
    localparam int VALUE_WIDTH_DEF = 64;
    localparam int CHAR_W          = 7;
    localparam int BASE_W          = 7;
    localparam int DIGIT_W         = 6;
    localparam int DIGIT_DEPTH     = 64;
    localparam int DIGIT_AW        = 6;
    localparam int CNT_W           = 7;
    localparam int DATA_W          = 32;
    localparam int ADDR_W          = 3;
    localparam int REG_IDX_W       = ADDR_W - 2;

    localparam logic [BASE_W-1:0]    BASE_RESET     = 7'd10;
    localparam logic [BASE_W-1:0]    BASE_MIN       = 7'd2;
    localparam logic [BASE_W-1:0]    BASE_MAX       = 7'd64;
    localparam logic [REG_IDX_W-1:0] REG_BASE_RADIX = 1'b0;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_FETCH,
        S_LOAD,
        S_OUT
    } t_state;

    typedef struct packed {
        logic load;
        logic step;
    } t_div_ctrl;

    typedef struct packed {
        logic done;
        logic quot_zero;
    } t_div_stat;

    // 0-9, a-z, A-Z, '+', '/'
    function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] c;
        case (d) inside
            [6'd0:6'd9]:   c = CHAR_W'(d) + 7'd48;
            [6'd10:6'd35]: c = CHAR_W'(d) + 7'd87;
            [6'd36:6'd61]: c = CHAR_W'(d) + 7'd29;
            6'd62:         c = 7'd43;
            default:       c = 7'd47;
        endcase
        return c;
    endfunction

endpackage

/* rtl/i2r_if.sv */
// Valid/ready channel interfaces for input values and output digits.
interface i2r_in_if
    import i2r_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic signed [IN_W-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface i2r_out_if
    import i2r_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] digit_char;
    logic              is_negative;
    logic              last;

    modport source (output valid, output digit_char, output is_negative, output last,
                    input ready);
    modport sink   (input valid, input digit_char, input is_negative, input last,
                    output ready);
endinterface

/* rtl/i2r_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module i2r_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/i2r_div.sv */
// Shared divide step: magnitude by small base, eight quotient bits per cycle while i_ctrl.step is high.
module i2r_div
    import i2r_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_div_ctrl              i_ctrl,
    input  logic [VALUE_WIDTH-1:0] i_mag,
    input  logic [BASE_W-1:0]      i_base,
    output logic [DIGIT_W-1:0]     o_rem,
    output t_div_stat              o_stat
);

    localparam int CHUNKS = (VALUE_WIDTH + 7) / 8;
    localparam int PAD_W  = CHUNKS * 8;
    localparam int CH_W   = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
    localparam logic [CH_W-1:0] CH_LAST = CH_W'(CHUNKS - 1);

    logic [PAD_W-1:0]   r_quot;
    logic [DIGIT_W-1:0] r_rem;
    logic [CH_W-1:0]    r_chunk;
    logic               r_done;

    logic [PAD_W-1:0]   n_quot;
    logic [DIGIT_W-1:0] n_rem;
    logic [BASE_W-1:0]  t_part;

    // remainder restarts from zero at the top of each digit
    always_comb begin
        n_quot = r_quot;
        n_rem  = (r_chunk == '0) ? '0 : r_rem;
        t_part = '0;
        for (int j = 0; j < 8; j++) begin
            t_part = {n_rem, n_quot[PAD_W-1]};
            n_quot = {n_quot[PAD_W-2:0], 1'b0};
            if (t_part >= i_base) begin
                t_part    = t_part - i_base;
                n_quot[0] = 1'b1;
            end
            n_rem = t_part[DIGIT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chunk <= '0;
            r_done  <= 1'b0;
        end else if (i_ctrl.load) begin
            r_chunk <= '0;
            r_done  <= 1'b0;
        end else if (i_ctrl.step) begin
            r_chunk <= (r_chunk == CH_LAST) ? '0 : r_chunk + 1'b1;
            r_done  <= (r_chunk == CH_LAST);
        end else begin
            r_done  <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_quot <= PAD_W'(i_mag);
        end else if (i_ctrl.step) begin
            r_quot <= n_quot;
            r_rem  <= n_rem;
        end
    end

    assign o_rem            = r_rem;
    assign o_stat.done      = r_done;
    assign o_stat.quot_zero = (r_quot == '0);

endmodule

/* rtl/int64_to_radix_text_unit.sv */
// Radix text unit: signed integer in, one ASCII digit per output transfer.
//
// Input channel i_in carries one two's complement value per transfer; only
// its low VALUE_WIDTH bits count. Output channel o_out returns the digits
// most significant first, each with is_negative, and last on the final one.
// The APB port holds base_radix at address 0 (reset 10); 0 and 1 act as 2,
// values above 64 act as 64. Write it only between conversions.
// i_in.ready is high only while no conversion is in progress.
// Each digit is worked out by the shared divide step, which retires eight
// quotient bits per cycle; then each digit leaves by RAM read, load and
// transfer, in that order.
// A stalled receiver holds the current digit steady; no new value is taken
// until the last digit has been transferred.
// Synchronous reset returns to idle with base 10; the digit RAM is not
// cleared, every entry read is written earlier in the same conversion.
module int64_to_radix_text_unit
    import i2r_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    i2r_in_if.sink            i_in,
    i2r_out_if.source         o_out,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    t_state r_state, n_state;

    logic [BASE_W-1:0]   r_base_cfg;
    logic [BASE_W-1:0]   r_base, n_base;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [DIGIT_AW-1:0] r_idx, n_idx;
    logic                r_neg, n_neg;
    logic [CHAR_W-1:0]   r_char, n_char;
    logic                r_last, n_last;

    logic [VALUE_WIDTH-1:0] raw;
    logic [VALUE_WIDTH-1:0] mag;
    logic [BASE_W-1:0]      base_eff;
    logic                   in_xfer;
    logic                   out_xfer;

    t_div_ctrl          div_ctrl;
    t_div_stat          div_stat;
    logic [DIGIT_W-1:0] div_rem;

    logic                ram_we;
    logic [DIGIT_W-1:0]  ram_rdata;

    assign pready = 1'b1;
    assign prdata = (paddr[ADDR_W-1:2] == REG_BASE_RADIX) ? DATA_W'(r_base_cfg) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_cfg <= BASE_RESET;
        end else if (psel && penable && pwrite && pready
                     && paddr[ADDR_W-1:2] == REG_BASE_RADIX) begin
            r_base_cfg <= pwdata[BASE_W-1:0];
        end
    end

    assign raw = i_in.value[VALUE_WIDTH-1:0];
    assign mag = raw[VALUE_WIDTH-1] ? (~raw + 1'b1) : raw;

    always_comb begin
        if (r_base_cfg < BASE_MIN) begin
            base_eff = BASE_MIN;
        end else if (r_base_cfg > BASE_MAX) begin
            base_eff = BASE_MAX;
        end else begin
            base_eff = r_base_cfg;
        end
    end

    assign i_in.ready  = (r_state == S_IDLE);
    assign in_xfer     = i_in.valid && i_in.ready;
    assign o_out.valid = (r_state == S_OUT);
    assign out_xfer    = o_out.valid && o_out.ready;

    assign o_out.digit_char  = r_char;
    assign o_out.is_negative = r_neg;
    assign o_out.last        = r_last;

    i2r_div #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (div_ctrl),
        .i_mag   (mag),
        .i_base  (r_base),
        .o_rem   (div_rem),
        .o_stat  (div_stat)
    );

    i2r_ram #(
        .WIDTH (DIGIT_W),
        .DEPTH (DIGIT_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_count[DIGIT_AW-1:0]),
        .i_wdata (div_rem),
        .i_raddr (r_idx),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state       = r_state;
        n_base        = r_base;
        n_count       = r_count;
        n_idx         = r_idx;
        n_neg         = r_neg;
        n_char        = r_char;
        n_last        = r_last;
        ram_we        = 1'b0;
        div_ctrl.load = 1'b0;
        div_ctrl.step = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    div_ctrl.load = 1'b1;
                    n_neg         = raw[VALUE_WIDTH-1];
                    n_base        = base_eff;
                    n_count       = '0;
                    n_state       = S_DIV;
                end
            end
            S_DIV: begin
                if (div_stat.done) begin
                    ram_we  = 1'b1;
                    n_count = r_count + 1'b1;
                    if (div_stat.quot_zero || r_count == CNT_W'(DIGIT_DEPTH - 1)) begin
                        n_idx   = r_count[DIGIT_AW-1:0];
                        n_state = S_FETCH;
                    end else begin
                        div_ctrl.step = 1'b1;
                    end
                end else begin
                    div_ctrl.step = 1'b1;
                end
            end
            S_FETCH: begin
                n_state = S_LOAD;
            end
            S_LOAD: begin
                n_char  = digit_to_ascii(ram_rdata);
                n_last  = (r_idx == '0);
                n_state = S_OUT;
            end
            S_OUT: begin
                if (out_xfer) begin
                    if (r_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx   = r_idx - 1'b1;
                        n_state = S_FETCH;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_base <= n_base;
        r_idx  <= n_idx;
        r_neg  <= n_neg;
        r_char <= n_char;
        r_last <= n_last;
    end

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in.ready && o_out.valid))
        else $error("input ready while a digit is pending");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DIGIT_DEPTH))
        else $error("digit count beyond store depth");

    a_div_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && div_stat.done && div_stat.quot_zero) |=> r_state == S_FETCH)
        else $error("conversion did not stop at zero quotient");

    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_xfer && o_out.last) |=> (r_state == S_IDLE && i_in.ready))
        else $error("no return to idle after last digit");

    a_last_first_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOAD) |=> (r_last == (r_idx == '0)))
        else $error("last flag not tied to first store entry");

endmodule
